@@ sv/pfbs_pkg.sv @@
// Shared types, constants and color arithmetic for the palette frame box scaler.
`timescale 1ns / 1ps
`default_nettype none

package pfbs_pkg;

    // Input command codes
    localparam logic [1:0] CMD_PAL_WR = 2'd0;
    localparam logic [1:0] CMD_FRM_WR = 2'd1;
    localparam logic [1:0] CMD_REQ    = 2'd2;

    // Task codes carried from the front end to the back end
    localparam logic [1:0] OP_PAL_WR = 2'd0;
    localparam logic [1:0] OP_FRM_WR = 2'd1;
    localparam logic [1:0] OP_REQ    = 2'd2;

    // Coordinate width wide enough for the largest supported source frame
    localparam int CW = 9;

    // Task queue depth and pointer widths
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    // Bits that must not carry into the next channel when halving RGB565
    localparam logic [15:0] RGB_HALF_MASK = 16'hF7DE;

    // One classified item on its way to the back end
    typedef struct packed {
        logic [1:0]    op;
        logic [CW-1:0] x0;
        logic [CW-1:0] x1;
        logic [CW-1:0] y0;
        logic [CW-1:0] y1;
        logic [7:0]    idx;
        logic [15:0]   val;
    } t_task;

    // Average two RGB565 colors per channel, rounding down
    function automatic logic [15:0] avg565(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] half;
        half   = ((a ^ b) & RGB_HALF_MASK) >> 1;
        avg565 = half + (a & b);
    endfunction

endpackage

`default_nettype wire

@@ sv/pfbs_fifo.sv @@
// Short task queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module pfbs_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  pfbs_pkg::t_task     i_data,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_empty,
    output pfbs_pkg::t_task     o_data
);

    pfbs_pkg::t_task                r_mem [pfbs_pkg::QDEPTH];
    logic [pfbs_pkg::QAW-1:0]       r_wr_ptr;
    logic [pfbs_pkg::QAW-1:0]       r_rd_ptr;
    logic [pfbs_pkg::QCW-1:0]       r_count;
    logic                           do_push;
    logic                           do_pop;

    // Status flags and guarded strobes
    always_comb begin
        o_full  = (r_count == pfbs_pkg::QCW'(pfbs_pkg::QDEPTH));
        o_empty = (r_count == '0);
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_data  = r_mem[r_rd_ptr];
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/pfbs_front.sv @@
// Front end: accepts items, maps display positions to source positions, classifies.
`timescale 1ns / 1ps
`default_nettype none

module pfbs_front #(
    parameter int SRC_W = 256,
    parameter int SRC_H = 240,
    parameter int OUT_W = 320,
    parameter int OUT_H = 240
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    output logic                o_full,
    input  wire  [1:0]          i_cmd,
    input  wire  [7:0]          i_src_x,
    input  wire  [7:0]          i_src_y,
    input  wire  [7:0]          i_color_index,
    input  wire  [15:0]         i_color_value,
    input  wire  [8:0]          i_out_x,
    input  wire  [7:0]          i_out_y,
    input  wire                 i_q_full,
    output logic                o_task_valid,
    output pfbs_pkg::t_task     o_task
);

    // Scale by multiplying with a rounded-up reciprocal; the shift is large
    // enough that the floor of the product equals the exact integer quotient
    // for every 9-bit column and 8-bit row up to an output size of 1024.
    localparam int          SH  = 19;
    localparam int unsigned KX  = (SRC_W * (1 << SH) + OUT_W - 1) / OUT_W;
    localparam int unsigned KY  = (SRC_H * (1 << SH) + OUT_H - 1) / OUT_H;
    localparam int          KXW = $clog2(KX + 1);
    localparam int          KYW = $clog2(KY + 1);
    localparam int          PXW = 9 + KXW;
    localparam int          PYW = 8 + KYW;
    localparam int          QXW = PXW - SH;
    localparam int          QYW = PYW - SH;

    logic                       r_fv;
    logic [1:0]                 r_cmd;
    logic [7:0]                 r_src_x;
    logic [7:0]                 r_src_y;
    logic [7:0]                 r_cidx;
    logic [15:0]                r_cval;
    logic [PXW-1:0]             r_prodx;
    logic [PYW-1:0]             r_prody;

    logic                       accept;
    logic                       keep;
    logic [QXW-1:0]             sx_q;
    logic [QYW-1:0]             sy_q;
    logic [pfbs_pkg::CW-1:0]    sx;
    logic [pfbs_pkg::CW-1:0]    sy;
    logic [pfbs_pkg::CW-1:0]    sx1;
    logic [pfbs_pkg::CW-1:0]    sy1;

    // Classify the held item and build its task
    always_comb begin
        sx_q = r_prodx[PXW-1:SH];
        sy_q = r_prody[PYW-1:SH];
        // Clamp requests that fall off the display
        if (32'(sx_q) > 32'(SRC_W - 1)) begin
            sx = pfbs_pkg::CW'(SRC_W - 1);
        end else begin
            sx = pfbs_pkg::CW'(sx_q);
        end
        if (32'(sy_q) > 32'(SRC_H - 1)) begin
            sy = pfbs_pkg::CW'(SRC_H - 1);
        end else begin
            sy = pfbs_pkg::CW'(sy_q);
        end
        // Clamp the right and lower neighbors at the frame edge
        sx1 = (sx == pfbs_pkg::CW'(SRC_W - 1)) ? sx : sx + 1'b1;
        sy1 = (sy == pfbs_pkg::CW'(SRC_H - 1)) ? sy : sy + 1'b1;

        o_task     = '0;
        o_task.idx = r_cidx;
        o_task.val = r_cval;
        case (r_cmd)
            pfbs_pkg::CMD_PAL_WR: begin
                keep      = 1'b1;
                o_task.op = pfbs_pkg::OP_PAL_WR;
            end
            pfbs_pkg::CMD_FRM_WR: begin
                // Drop pixel writes outside the frame
                keep      = (32'(r_src_x) < 32'(SRC_W)) && (32'(r_src_y) < 32'(SRC_H));
                o_task.op = pfbs_pkg::OP_FRM_WR;
                o_task.x0 = pfbs_pkg::CW'(r_src_x);
                o_task.y0 = pfbs_pkg::CW'(r_src_y);
            end
            pfbs_pkg::CMD_REQ: begin
                keep      = 1'b1;
                o_task.op = pfbs_pkg::OP_REQ;
                o_task.x0 = sx;
                o_task.x1 = sx1;
                o_task.y0 = sy;
                o_task.y1 = sy1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase

        o_task_valid = r_fv && keep;
        o_full       = r_fv && keep && i_q_full;
        accept       = i_push && !o_full;
    end

    // Hold an item until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= accept || o_full;
        end
    end

    // Capture the item and start the coordinate scaling
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_src_x <= i_src_x;
            r_src_y <= i_src_y;
            r_cidx  <= i_color_index;
            r_cval  <= i_color_value;
            r_prodx <= PXW'(i_out_x) * PXW'(KX);
            r_prody <= PYW'(i_out_y) * PYW'(KY);
        end
    end

endmodule

`default_nettype wire

@@ sv/pfbs_back.sv @@
// Back end: palette and frame memories, 2x2 fetch sequencer, averaging and result register.
`timescale 1ns / 1ps
`default_nettype none

module pfbs_back #(
    parameter int SRC_W = 256,
    parameter int SRC_H = 240
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_blank,
    input  wire                 i_q_empty,
    input  pfbs_pkg::t_task     i_q_data,
    output logic                o_q_pop,
    input  wire                 i_pop,
    output logic                o_empty,
    output logic [15:0]         o_pixel_swapped
);

    localparam int XW     = $clog2(SRC_W);
    localparam int YW     = $clog2(SRC_H);
    localparam int AW     = XW + YW;
    localparam int FDEPTH = SRC_H * (1 << XW);

    localparam logic       ST_IDLE   = 1'b0;
    localparam logic       ST_BUSY   = 1'b1;
    localparam logic [2:0] STEP_TOP  = 3'd3;
    localparam logic [2:0] STEP_C2   = 3'd4;
    localparam logic [2:0] STEP_C0   = 3'd2;
    localparam logic [2:0] STEP_LAST = 3'd5;

    logic [15:0]                r_palette [256];
    logic [7:0]                 r_frame [FDEPTH];

    logic                       r_state;
    logic [2:0]                 r_step;
    logic                       r_out_valid;
    logic [15:0]                r_out_data;
    pfbs_pkg::t_task            r_task;
    logic                       r_blank_req;
    logic [7:0]                 r_fdat;
    logic [15:0]                r_pdat;
    logic [15:0]                r_c0;
    logic [15:0]                r_top;

    logic                       out_free;
    logic                       pal_we;
    logic                       frm_we;
    logic                       frm_re;
    logic                       pal_re;
    logic                       finish;
    logic [pfbs_pkg::CW-1:0]    rd_x;
    logic [pfbs_pkg::CW-1:0]    rd_y;
    logic [AW-1:0]              frm_addr;
    logic [15:0]                bot;
    logic [15:0]                avg;

    // Decode memory strobes and the current fetch address
    always_comb begin
        out_free = !r_out_valid || i_pop;
        o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;
        pal_we   = o_q_pop && (i_q_data.op == pfbs_pkg::OP_PAL_WR);
        frm_we   = o_q_pop && (i_q_data.op == pfbs_pkg::OP_FRM_WR);
        frm_re   = (r_state == ST_BUSY) && !r_blank_req && (r_step < 3'd4);
        pal_re   = (r_state == ST_BUSY) && !r_blank_req && (r_step inside {[3'd1:3'd4]});
        finish   = (r_state == ST_BUSY) && (r_step == STEP_LAST) && out_free;

        // Neighbor order: top left, top right, bottom left, bottom right
        rd_x = r_step[0] ? r_task.x1 : r_task.x0;
        rd_y = r_step[1] ? r_task.y1 : r_task.y0;
        if (frm_we) begin
            frm_addr = {i_q_data.y0[YW-1:0], i_q_data.x0[XW-1:0]};
        end else begin
            frm_addr = {rd_y[YW-1:0], rd_x[XW-1:0]};
        end

        bot = pfbs_pkg::avg565(r_c0, r_pdat);
        avg = pfbs_pkg::avg565(r_top, bot);

        o_empty         = !r_out_valid;
        o_pixel_swapped = r_out_data;
    end

    // Sequence one task at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_q_pop && (i_q_data.op == pfbs_pkg::OP_REQ)) begin
                        r_state <= ST_BUSY;
                        r_step  <= i_blank ? STEP_LAST : 3'd0;
                    end
                end
                ST_BUSY: begin
                    if (r_step != STEP_LAST) begin
                        r_step <= r_step + 1'b1;
                    end else if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Latch the request and collect neighbor colors
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_task      <= i_q_data;
            r_blank_req <= i_blank;
        end
        if (r_state == ST_BUSY && r_step == STEP_C0) begin
            r_c0 <= r_pdat;
        end
        if (r_state == ST_BUSY && r_step == STEP_C2) begin
            r_c0 <= r_pdat;
        end
        if (r_state == ST_BUSY && r_step == STEP_TOP) begin
            r_top <= pfbs_pkg::avg565(r_c0, r_pdat);
        end
        // Swap bytes of the final color, or send black while blanking
        if (finish) begin
            r_out_data <= r_blank_req ? 16'h0000 : {avg[7:0], avg[15:8]};
        end
    end

    // Palette memory, one port
    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_palette[i_q_data.idx] <= i_q_data.val;
        end
        if (pal_re) begin
            r_pdat <= r_palette[r_fdat];
        end
    end

    // Frame memory, one port shared by writes and neighbor fetches
    always_ff @(posedge i_clk) begin
        if (frm_we) begin
            r_frame[frm_addr] <= i_q_data.idx;
        end
        if (frm_re) begin
            r_fdat <= r_frame[frm_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/palette_frame_box_scaler_core.sv @@
// Top level: configuration registers and the front end, task queue and back end.
//
// Usage:
//   Input items arrive on push/full and carry a command: write a palette entry,
//   write a frame pixel, or request one output pixel. Writes give no result; a
//   request gives one 16-bit byte-swapped RGB565 pixel on empty/pop.
//   The blank_output register (APB byte address 0, bit 0) forces results to 0;
//   write it only while no items are in flight.
// Operation:
//   The back end handles one task at a time. For a request it takes the task,
//   reads the 2x2 neighbors in turn through the single frame-memory port, then
//   finishes the last palette lookup and the averaging. A write completes as
//   it is taken; a blanked request skips the neighbor fetches. The front end
//   and a 4-entry task queue keep taking items while the back end works.
// Reset and stalls:
//   Reset empties the queue and the result register and clears blank_output;
//   palette and frame contents stay undefined until written. While the result
//   is not popped, writes still drain, the next request waits for the result
//   register, and full rises once the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module palette_frame_box_scaler_core #(
    parameter int SRC_W = 256,
    parameter int SRC_H = 240,
    parameter int OUT_W = 320,
    parameter int OUT_H = 240
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         push,
    output logic        full,
    input  wire  [1:0]  i_cmd,
    input  wire  [7:0]  i_src_x,
    input  wire  [7:0]  i_src_y,
    input  wire  [7:0]  i_color_index,
    input  wire  [15:0] i_color_value,
    input  wire  [8:0]  i_out_x,
    input  wire  [7:0]  i_out_y,
    output logic        empty,
    input  wire         pop,
    output logic [15:0] o_pixel_swapped
);

    localparam logic REG_BLANK = 1'b0;

    logic               r_blank;
    logic               cfg_wr;
    logic               task_valid;
    pfbs_pkg::t_task    task_in;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    pfbs_pkg::t_task    q_data;

    // Register access decode
    always_comb begin
        pready = 1'b1;
        cfg_wr = psel && penable && pwrite && pready;
        prdata = (paddr[2] == REG_BLANK) ? {31'd0, r_blank} : 32'd0;
    end

    // Blanking control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank <= 1'b0;
        end else if (cfg_wr && (paddr[2] == REG_BLANK)) begin
            r_blank <= pwdata[0];
        end
    end

    pfbs_front #(
        .SRC_W (SRC_W),
        .SRC_H (SRC_H),
        .OUT_W (OUT_W),
        .OUT_H (OUT_H)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_cmd         (i_cmd),
        .i_src_x       (i_src_x),
        .i_src_y       (i_src_y),
        .i_color_index (i_color_index),
        .i_color_value (i_color_value),
        .i_out_x       (i_out_x),
        .i_out_y       (i_out_y),
        .i_q_full      (q_full),
        .o_task_valid  (task_valid),
        .o_task        (task_in)
    );

    pfbs_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (task_valid),
        .i_data  (task_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    pfbs_back #(
        .SRC_W (SRC_W),
        .SRC_H (SRC_H)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_blank         (r_blank),
        .i_q_empty       (q_empty),
        .i_q_data        (q_data),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_pixel_swapped (o_pixel_swapped)
    );

endmodule

`default_nettype wire

@@ sv/pfbs_checker.sv @@
// Port-level checks for the scaler core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pfbs_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire  [31:0] prdata,
    input  wire         pready,
    input  wire         full,
    input  wire         empty,
    input  wire         pop,
    input  wire  [15:0] o_pixel_swapped
);

    // Reset leaves no result waiting and the input open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("result or full flag survived reset");

    // A waiting result holds until it is popped
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pixel_swapped)))
        else $error("waiting result changed or vanished");

    // The blanking register reads back what was written
    a_blank_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2]
        |-> (prdata[0] == $past(pwdata[0])))
        else $error("blank_output readback mismatch");

    // Upper register bits read as zero
    a_blank_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prdata[31:1] == 31'd0)
        else $error("unused register bits not zero");

endmodule

bind palette_frame_box_scaler_core pfbs_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_pixel_swapped (o_pixel_swapped)
);

`default_nettype wire
